FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file tcpq_checker
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/tcpq_pkg.sv
// shared types, codes and helpers for the out-of-order segment queue
// depends on nothing
package tcpq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int MAX_OUT   = 32;

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_DEQ    = 3'd2;
  localparam logic [2:0] REQ_GATHER = 3'd3;
  localparam logic [2:0] REQ_COVER  = 3'd4;

  // status codes
  localparam logic [2:0] STAT_OK   = 3'd0;
  localparam logic [2:0] STAT_DUP  = 3'd1;
  localparam logic [2:0] STAT_FIN  = 3'd2;
  localparam logic [2:0] STAT_FULL = 3'd3;
  localparam logic [2:0] STAT_NONE = 3'd4;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SCAN,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     append;
    entry_t   new_ent;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_WALK
  } state_t;

  // a is after b in wrapping sequence order
  function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  // a is not before b
  function automatic logic seq_not_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31];
  endfunction

endpackage

FILE: rtl/core/tcpq_cell.sv
// one slot of the sorted segment chain
// depends on tcpq_pkg; neighbors feed it their words for shifts
module tcpq_cell #(
  parameter int DEPTH = tcpq_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  tcpq_pkg::cell_ctl_t        ctl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  tcpq_pkg::entry_t           left_ent,
  input  tcpq_pkg::entry_t           right_ent,
  input  logic                       seen_in,
  output tcpq_pkg::entry_t           ent,
  output logic                       seen_out,
  output logic                       first_dup,
  output logic [31:0]                tail_seq,
  output logic                       tail_fin
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] IdxC = CW'(IDX);

  tcpq_pkg::entry_t ent_r;
  logic dup_r, aft_r, valid_r;
  logic hit, is_tail;

  // scan result of this slot
  assign hit       = valid_r && (dup_r || aft_r);
  assign seen_out  = seen_in || hit;
  assign first_dup = hit && !seen_in && dup_r;

  // tail word, zero unless this slot is the tail
  assign is_tail  = (count != '0) && (IdxC == count - CW'(1));
  assign tail_seq = is_tail ? ent_r.seq : 32'd0;
  assign tail_fin = is_tail && ent_r.fin;
  assign ent      = ent_r;

  // slot update
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      tcpq_pkg::OP_SCAN: begin
        dup_r   <= (ent_r.seq == ctl.new_ent.seq) && (ent_r.len == ctl.new_ent.len);
        aft_r   <= tcpq_pkg::seq_after(ent_r.seq, ctl.new_ent.seq);
        valid_r <= IdxC < count;
      end
      tcpq_pkg::OP_INSERT: begin
        if (ctl.append) begin
          if (IdxC == count) ent_r <= ctl.new_ent;
        end else if (seen_in) begin
          ent_r <= left_ent;
        end else if (hit) begin
          ent_r <= ctl.new_ent;
        end
      end
      tcpq_pkg::OP_SHIFT: ent_r <= right_ent;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/tcp_out_of_order_segment_queue.sv
// top level of the out-of-order segment queue: control, counters, result word
// depends on tcpq_pkg and tcpq_cell
//
// A request is taken when start is high and busy low. Insert, append, dequeue
// and unused codes pass through accept, scan of all slots and apply, and give
// one result. Gather and cover rotate the whole slot chain once past slot 0,
// one slot a cycle; gather gives one run word the cycle after that run is
// closed. Each result is shown for one cycle with out_valid; the receiver
// cannot stall, so it must take every word.
module tcp_out_of_order_segment_queue #(
  parameter int DEPTH = tcpq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_seq,
  input  logic [15:0] in_data_len,
  input  logic        in_fin,
  input  logic [15:0] in_handle,
  input  logic [5:0]  in_max_plugs,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_seq,
  output logic [15:0] out_len,
  output logic        out_fin,
  output logic [15:0] out_handle,
  output logic [31:0] out_run_start,
  output logic [31:0] out_run_end,
  output logic [31:0] out_byte_count,
  output logic        out_last
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [5:0]    MaxOutC = 6'(tcpq_pkg::MAX_OUT);

  tcpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [31:0]   lastins_r, lastins_nxt;
  logic [2:0]    req_r;
  tcpq_pkg::entry_t req_ent_r;
  logic [5:0]    maxp_r;
  logic [31:0]   tail_seq_r;
  logic          tail_fin_r;
  logic [CW-1:0] j_r, j_nxt;
  logic [5:0]    n_r, n_nxt;
  logic [31:0]   lo_r, lo_nxt, up_r, up_nxt;
  logic          gdone_r, gdone_nxt;
  logic          found_r, found_nxt, fail_r, fail_nxt;
  logic [31:0]   flo_r, flo_nxt, fup_r, fup_nxt;

  logic          ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]    ostat_r, ostat_nxt;
  tcpq_pkg::entry_t oent_r, oent_nxt;
  logic [31:0]   olo_r, olo_nxt, oup_r, oup_nxt, obytes_r, obytes_nxt;

  tcpq_pkg::cell_ctl_t ctl;
  tcpq_pkg::entry_t    ents [DEPTH];
  logic [DEPTH:0]      seen;
  logic [DEPTH-1:0]    fdup, tfin;
  logic [31:0]         tseq [DEPTH];
  logic                any_dup, any_tfin;
  logic [31:0]         any_tseq;

  // slot chain
  assign seen[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tcpq_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .left_ent  (ents[(g == 0) ? 0 : g-1]),
      .right_ent (ents[(g == DEPTH-1) ? 0 : g+1]),
      .seen_in   (seen[g]),
      .ent       (ents[g]),
      .seen_out  (seen[g+1]),
      .first_dup (fdup[g]),
      .tail_seq  (tseq[g]),
      .tail_fin  (tfin[g])
    );
  end

  // or-reduce of the slot flags
  always_comb begin
    any_tseq = 32'd0;
    for (int i = 0; i < DEPTH; i++) any_tseq = any_tseq | tseq[i];
  end
  assign any_dup  = |fdup;
  assign any_tfin = |tfin;

  assign busy = (state_r != tcpq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcpq_pkg::S_IDLE:
        if (start) begin
          if (in_req_type == tcpq_pkg::REQ_GATHER || in_req_type == tcpq_pkg::REQ_COVER)
            state_nxt = tcpq_pkg::S_WALK;
          else
            state_nxt = tcpq_pkg::S_SCAN;
        end
      tcpq_pkg::S_SCAN:  state_nxt = tcpq_pkg::S_APPLY;
      tcpq_pkg::S_APPLY: state_nxt = tcpq_pkg::S_IDLE;
      tcpq_pkg::S_WALK:  if (j_r == DepthC) state_nxt = tcpq_pkg::S_IDLE;
      default:           state_nxt = tcpq_pkg::S_IDLE;
    endcase
  end

  // datapath and result word
  always_comb begin
    logic       append_mode, at_tail, cont, rchk, cov_ok;
    logic [2:0] st;
    logic [5:0] maxe;
    ctl.op      = tcpq_pkg::OP_HOLD;
    ctl.append  = 1'b0;
    ctl.new_ent = req_ent_r;
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    lastins_nxt = lastins_r;
    j_nxt = j_r; n_nxt = n_r; lo_nxt = lo_r; up_nxt = up_r;
    gdone_nxt = gdone_r; found_nxt = found_r; fail_nxt = fail_r;
    flo_nxt = flo_r; fup_nxt = fup_r;
    ov_nxt = 1'b0; olast_nxt = 1'b1; ostat_nxt = tcpq_pkg::STAT_NONE;
    oent_nxt = '0; olo_nxt = 32'd0; oup_nxt = 32'd0; obytes_nxt = bytes_r;
    append_mode = 1'b0; at_tail = 1'b0; cont = 1'b0; rchk = 1'b0; cov_ok = 1'b0;
    st   = tcpq_pkg::STAT_OK;
    maxe = (maxp_r > MaxOutC) ? MaxOutC : maxp_r;

    unique case (state_r)
      tcpq_pkg::S_IDLE: begin
        j_nxt = '0; n_nxt = 6'd0; gdone_nxt = 1'b0;
        found_nxt = 1'b0; fail_nxt = 1'b0;
      end
      tcpq_pkg::S_SCAN: ctl.op = tcpq_pkg::OP_SCAN;
      tcpq_pkg::S_APPLY: begin
        ov_nxt = 1'b1;
        if (req_r == tcpq_pkg::REQ_INSERT || req_r == tcpq_pkg::REQ_APPEND) begin
          append_mode = (req_r == tcpq_pkg::REQ_APPEND) || (count_r == '0) ||
                        tcpq_pkg::seq_after(req_ent_r.seq, tail_seq_r);
          at_tail = append_mode || !seen[DEPTH];
          if (!append_mode && any_dup)
            st = tcpq_pkg::STAT_DUP;
          else if (at_tail && count_r != '0 && tail_fin_r && req_ent_r.fin)
            st = tcpq_pkg::STAT_FIN;
          else if (count_r >= DepthC)
            st = tcpq_pkg::STAT_FULL;
          else
            st = tcpq_pkg::STAT_OK;
          ostat_nxt = st;
          if (st == tcpq_pkg::STAT_OK) begin
            ctl.op      = tcpq_pkg::OP_INSERT;
            ctl.append  = at_tail;
            count_nxt   = count_r + CW'(1);
            bytes_nxt   = bytes_r + 32'(req_ent_r.len);
            lastins_nxt = req_ent_r.seq;
          end
          obytes_nxt = bytes_nxt;
        end else if (req_r == tcpq_pkg::REQ_DEQ && count_r != '0) begin
          ctl.op     = tcpq_pkg::OP_SHIFT;
          count_nxt  = count_r - CW'(1);
          bytes_nxt  = bytes_r - 32'(ents[0].len);
          ostat_nxt  = tcpq_pkg::STAT_OK;
          oent_nxt   = ents[0];
          obytes_nxt = bytes_nxt;
        end
      end
      tcpq_pkg::S_WALK: begin
        j_nxt = j_r + CW'(1);
        if (j_r < DepthC) ctl.op = tcpq_pkg::OP_SHIFT;
        if (j_r < count_r) begin
          // one slot of the walk: extend the open run or close it
          cont = (j_r != '0) && (ents[0].seq == up_r);
          if (j_r == '0 && tcpq_pkg::seq_after(ents[0].seq, lastins_r)) fail_nxt = 1'b1;
          if (cont) begin
            up_nxt = up_r + 32'(ents[0].len);
          end else begin
            if (j_r != '0) begin
              if (req_r == tcpq_pkg::REQ_GATHER) begin
                if (!gdone_r && n_r < maxe) begin
                  ov_nxt = 1'b1; ostat_nxt = tcpq_pkg::STAT_OK;
                  olo_nxt = lo_r; oup_nxt = up_r;
                  olast_nxt = (n_r + 6'd1 == maxe);
                  n_nxt = n_r + 6'd1;
                  gdone_nxt = olast_nxt;
                end
              end else begin
                rchk = tcpq_pkg::seq_not_before(lastins_r, lo_r) &&
                       tcpq_pkg::seq_after(up_r, lastins_r);
                if (rchk && !found_r) begin
                  found_nxt = 1'b1; flo_nxt = lo_r; fup_nxt = up_r;
                end
              end
            end
            lo_nxt = ents[0].seq;
            up_nxt = ents[0].seq + 32'(ents[0].len);
          end
        end
        if (j_r == count_r) begin
          // close the last run and finish the request
          if (req_r == tcpq_pkg::REQ_GATHER) begin
            if (count_r == '0 || maxe == 6'd0) begin
              ov_nxt = 1'b1; ostat_nxt = tcpq_pkg::STAT_NONE;
            end else if (!gdone_r) begin
              ov_nxt = 1'b1; ostat_nxt = tcpq_pkg::STAT_OK;
              olo_nxt = lo_r; oup_nxt = up_r;
            end
          end else begin
            rchk = (count_r != '0) && tcpq_pkg::seq_not_before(lastins_r, lo_r) &&
                   tcpq_pkg::seq_after(up_r, lastins_r);
            cov_ok = (count_r != '0) && !fail_r && (found_r || rchk);
            ov_nxt = 1'b1;
            if (cov_ok) begin
              ostat_nxt = tcpq_pkg::STAT_OK;
              olo_nxt = found_r ? flo_r : lo_r;
              oup_nxt = found_r ? fup_r : up_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcpq_pkg::S_IDLE;
      count_r   <= '0;
      bytes_r   <= 32'd0;
      lastins_r <= 32'd0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      bytes_r   <= bytes_nxt;
      lastins_r <= lastins_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // request latch, walk state and result word
  always_ff @(posedge clk) begin
    if (state_r == tcpq_pkg::S_IDLE && start) begin
      req_r            <= in_req_type;
      req_ent_r.seq    <= in_seq;
      req_ent_r.len    <= in_data_len;
      req_ent_r.fin    <= in_fin;
      req_ent_r.handle <= in_handle;
      maxp_r           <= in_max_plugs;
    end
    if (state_r == tcpq_pkg::S_SCAN) begin
      tail_seq_r <= any_tseq;
      tail_fin_r <= any_tfin;
    end
    j_r <= j_nxt; n_r <= n_nxt; lo_r <= lo_nxt; up_r <= up_nxt;
    gdone_r <= gdone_nxt; found_r <= found_nxt; fail_r <= fail_nxt;
    flo_r <= flo_nxt; fup_r <= fup_nxt;
    olast_r <= olast_nxt; ostat_r <= ostat_nxt; oent_r <= oent_nxt;
    olo_r <= olo_nxt; oup_r <= oup_nxt; obytes_r <= obytes_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_seq        = oent_r.seq;
  assign out_len        = oent_r.len;
  assign out_fin        = oent_r.fin;
  assign out_handle     = oent_r.handle;
  assign out_run_start  = olo_r;
  assign out_run_end    = oup_r;
  assign out_byte_count = obytes_r;
  assign out_last       = out_valid && olast_r;

endmodule

FILE: rtl/core/tcpq_checker.sv
// port-level checks for the out-of-order segment queue, bound to the top level
// depends on assert_macros.svh and tcpq_pkg
`include "assert_macros.svh"

module tcpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic        out_last
);

  // an accepted word makes the block busy
  `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  // refusals and not-found are always the final result
  `ASSERT_SAME(a_err_is_last, clk, rst_n, out_valid && out_status != tcpq_pkg::STAT_OK, out_last)
  // nothing follows the final result in the next cycle
  `ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid && out_last, !out_valid)

endmodule

bind tcp_out_of_order_segment_queue tcpq_checker u_tcpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);

FILE: dv/tb_tcp_out_of_order_segment_queue.sv
// testbench for the out-of-order segment queue: directed and random requests
// checked word by word against a behavioral model of the sorted table
// depends on tcpq_pkg and the tcp_out_of_order_segment_queue rtl
module tb_tcp_out_of_order_segment_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = tcpq_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  // request codes with no meaning, answered with not-found
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic [15:0] handle;
    logic [5:0]  maxp;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] dseq;
    logic [15:0] dlen;
    logic        dfin;
    logic [15:0] dhandle;
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] bytes;
    logic        last;
  } word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_seq = '0;
  logic [15:0] in_data_len = '0;
  logic        in_fin = 0;
  logic [15:0] in_handle = '0;
  logic [5:0]  in_max_plugs = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_seq;
  logic [15:0] out_len;
  logic        out_fin;
  logic [15:0] out_handle;
  logic [31:0] out_run_start;
  logic [31:0] out_run_end;
  logic [31:0] out_byte_count;
  logic        out_last;

  tcp_out_of_order_segment_queue u_top (.*);

  always #10 clk = ~clk;

  // model of the segment table
  tcpq_pkg::entry_t tbl[QDEPTH];
  int         tbl_cnt = 0;
  logic [31:0] held_bytes = '0;
  logic [31:0] last_stored = '0;

  request_t pending_reqs[$];
  word_t    expected_words[$];
  int       errors = 0;
  bit       stimulus_done = 0;
  bit       quiet_tail = 0;

  function automatic bit after_seq(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  function automatic bit not_before_seq(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31];
  endfunction

  function automatic word_t blank_word(logic [2:0] st);
    word_t w;
    w = '0;
    w.status = st;
    w.bytes = held_bytes;
    w.last = 1;
    return w;
  endfunction

  // index just past the contiguous run from index i, bounds out
  function automatic int run_end(int i, output logic [31:0] lo, output logic [31:0] up);
    logic [31:0] u;
    u = tbl[i].seq + tbl[i].len;
    lo = tbl[i].seq;
    i++;
    while (i < tbl_cnt && tbl[i].seq == u) begin
      u += tbl[i].len;
      i++;
    end
    up = u;
    return i;
  endfunction

  function automatic logic [2:0] store_segment(int pos, bit dup, request_t r);
    if (dup) return tcpq_pkg::STAT_DUP;
    if (pos == tbl_cnt && tbl_cnt > 0 && tbl[tbl_cnt-1].fin && r.fin) return tcpq_pkg::STAT_FIN;
    if (tbl_cnt >= QDEPTH) return tcpq_pkg::STAT_FULL;
    for (int i = tbl_cnt; i > pos; i--) tbl[i] = tbl[i-1];
    tbl[pos] = '{r.seq, r.len, r.fin, r.handle};
    tbl_cnt++;
    held_bytes += r.len;
    last_stored = r.seq;
    return tcpq_pkg::STAT_OK;
  endfunction

  // work out the words one request should give
  function automatic void predict_request(request_t r);
    int pos, i, n, lim;
    bit dup;
    logic [31:0] lo, up;
    logic [2:0] st;
    word_t w;
    case (r.req)
      tcpq_pkg::REQ_INSERT: begin
        pos = tbl_cnt;
        dup = 0;
        if (tbl_cnt > 0 && !after_seq(r.seq, tbl[tbl_cnt-1].seq)) begin
          for (i = 0; i < tbl_cnt; i++) begin
            if (tbl[i].seq == r.seq && tbl[i].len == r.len) begin
              dup = 1;
              break;
            end
            if (after_seq(tbl[i].seq, r.seq)) begin
              pos = i;
              break;
            end
          end
        end
        st = store_segment(pos, dup, r);
        expected_words.push_back(blank_word(st));
      end
      tcpq_pkg::REQ_APPEND: begin
        st = store_segment(tbl_cnt, 0, r);
        expected_words.push_back(blank_word(st));
      end
      tcpq_pkg::REQ_DEQ: begin
        if (tbl_cnt == 0) expected_words.push_back(blank_word(tcpq_pkg::STAT_NONE));
        else begin
          w = '0;
          w.dseq = tbl[0].seq;
          w.dlen = tbl[0].len;
          w.dfin = tbl[0].fin;
          w.dhandle = tbl[0].handle;
          for (i = 1; i < tbl_cnt; i++) tbl[i-1] = tbl[i];
          tbl_cnt--;
          held_bytes -= 32'(w.dlen);
          w.status = tcpq_pkg::STAT_OK;
          w.bytes = held_bytes;
          w.last = 1;
          expected_words.push_back(w);
        end
      end
      tcpq_pkg::REQ_GATHER: begin
        lim = (r.maxp > tcpq_pkg::MAX_OUT) ? tcpq_pkg::MAX_OUT : int'(r.maxp);
        n = 0;
        i = 0;
        while (i < tbl_cnt && n < lim) begin
          i = run_end(i, lo, up);
          w = blank_word(tcpq_pkg::STAT_OK);
          w.lower = lo;
          w.upper = up;
          w.last = 0;
          expected_words.push_back(w);
          n++;
        end
        if (n == 0) expected_words.push_back(blank_word(tcpq_pkg::STAT_NONE));
        else expected_words[$].last = 1;
      end
      tcpq_pkg::REQ_COVER: begin
        w = blank_word(tcpq_pkg::STAT_NONE);
        if (tbl_cnt > 0 && !after_seq(tbl[0].seq, last_stored)) begin
          i = 0;
          while (i < tbl_cnt) begin
            i = run_end(i, lo, up);
            if (not_before_seq(last_stored, lo) && after_seq(up, last_stored)) begin
              w.status = tcpq_pkg::STAT_OK;
              w.lower = lo;
              w.upper = up;
              break;
            end
          end
        end
        expected_words.push_back(w);
      end
      default: expected_words.push_back(blank_word(tcpq_pkg::STAT_NONE));
    endcase
  endfunction

  // driver: one request word per accept, random idle bursts
  int idle_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_request(pending_reqs.pop_front());
        if (!quiet_tail && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 16);
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 0;
      end else if (pending_reqs.size() > 0) begin
        start <= 1;
        in_req_type <= pending_reqs[0].req;
        in_seq <= pending_reqs[0].seq;
        in_data_len <= pending_reqs[0].len;
        in_fin <= pending_reqs[0].fin;
        in_handle <= pending_reqs[0].handle;
        in_max_plugs <= pending_reqs[0].maxp;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word, status %0d", out_status);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_status); errors++;
        end
        if (out_seq !== w.dseq) begin
          $error("out_seq exp %h got %h", w.dseq, out_seq); errors++;
        end
        if (out_len !== w.dlen) begin
          $error("out_len exp %h got %h", w.dlen, out_len); errors++;
        end
        if (out_fin !== w.dfin) begin
          $error("out_fin exp %b got %b", w.dfin, out_fin); errors++;
        end
        if (out_handle !== w.dhandle) begin
          $error("out_handle exp %h got %h", w.dhandle, out_handle); errors++;
        end
        if (out_run_start !== w.lower) begin
          $error("out_run_start exp %h got %h", w.lower, out_run_start); errors++;
        end
        if (out_run_end !== w.upper) begin
          $error("out_run_end exp %h got %h", w.upper, out_run_end); errors++;
        end
        if (out_byte_count !== w.bytes) begin
          $error("byte_count exp %h got %h", w.bytes, out_byte_count); errors++;
        end
        if (out_last !== w.last) begin
          $error("last exp %b got %b", w.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or result word
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void add_req(logic [2:0] req, logic [31:0] s, logic [15:0] l,
                                  logic f, logic [15:0] h, logic [5:0] mp);
    request_t r;
    r = '{req, s, l, f, h, mp};
    pending_reqs.push_back(r);
  endfunction

  // stimulus
  initial begin
    logic [31:0] base, cur;
    int n, k;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: empty cases, wrap, duplicate, second fin, full table
    add_req(tcpq_pkg::REQ_DEQ, 0, 0, 0, 0, 0);
    add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 32);
    add_req(tcpq_pkg::REQ_COVER, 0, 0, 0, 0, 0);
    add_req(REQ_SPARE_FIRST, '1, '1, 1, '1, '1);
    add_req(REQ_SPARE_LAST, 0, 0, 0, 0, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'hFFFF_FFF0, 16'h0010, 0, 16'hFFFF, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'h0000_0010, 16'hFFFF, 1, 16'h0000, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'h0000_0000, 16'h0010, 0, 16'h1234, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'h0000_0000, 16'h0010, 0, 16'h4321, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'h0000_0010, 16'h0010, 0, 16'h5555, 0);
    add_req(tcpq_pkg::REQ_APPEND, 32'h0001_0010, 16'h0, 1, 16'hAAAA, 0);
    add_req(tcpq_pkg::REQ_INSERT, 32'h0001_0010, 16'h0005, 1, 16'hAAAA, 0);
    add_req(tcpq_pkg::REQ_COVER, 0, 0, 0, 0, 0);
    add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 0);
    add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 63);
    add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 1);
    for (int i = 0; i < 30; i++)
      add_req(tcpq_pkg::REQ_APPEND, 32'(32'h7000_0000 + i * 40), 16'd20, 0, 16'(i), 0);
    add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 32);
    for (int i = 0; i < 36; i++) add_req(tcpq_pkg::REQ_DEQ, 0, 0, 0, 0, 0);

    // random: mostly contiguous segment streams in ascending order
    n = 0;
    while (n < 170) begin
      if ($urandom_range(0, 9) < 7) begin
        base = $urandom;
        cur = base;
        k = $urandom_range(2, 8);
        for (int i = 0; i < k; i++) begin
          logic [15:0] l;
          l = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
          add_req(($urandom_range(0, 3) == 0) ? tcpq_pkg::REQ_APPEND : tcpq_pkg::REQ_INSERT,
                  ($urandom_range(0, 4) == 0) ? cur + $urandom_range(1, 50) : cur,
                  l, $urandom_range(0, 5) == 0, 16'($urandom), 6'($urandom));
          cur += l;
          n++;
        end
        add_req(tcpq_pkg::REQ_COVER, $urandom, 0, 0, 0, 0);
        add_req(tcpq_pkg::REQ_GATHER, 0, 0, 0, 0, 6'($urandom_range(0, 40)));
        n += 2;
        if ($urandom_range(0, 3) == 0) begin
          // insert a zero-length segment at the base of the same stream
          add_req(tcpq_pkg::REQ_INSERT, base, 0, 0, 0, 0);
          n++;
        end
        k = $urandom_range(0, 10);
        for (int i = 0; i < k; i++) add_req(tcpq_pkg::REQ_DEQ, 0, 0, 0, 0, 0);
        n += k;
      end else begin
        add_req(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'($urandom),
                16'($urandom), 6'($urandom));
        n++;
      end
      if (n > 130) quiet_tail = 1;
    end
    quiet_tail = 1;

    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (start || busy || expected_words.size() != 0) @(posedge clk);
    repeat (QDEPTH + 10) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_cell.sv
rtl/core/tcp_out_of_order_segment_queue.sv
rtl/core/tcpq_checker.sv
dv/tb_tcp_out_of_order_segment_queue.sv
